// ===== rtl/core/hrv_pkg.sv =====
// hrv_pkg: types, codes, constants and helpers shared by the request validator
// depends on nothing; used by every file under rtl/core except hrv_intf
package hrv_pkg;

  localparam int unsigned APB_ADDR_W = 6;
  localparam int unsigned APB_DATA_W = 64;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);

  localparam int unsigned STR_LEN_W = 4;
  localparam logic [STR_LEN_W-1:0] STR_MAX  = 4'd8;
  localparam logic [STR_LEN_W-1:0] STR_OVER = 4'd9;

  localparam int unsigned NL_W = 9;

  localparam logic [7:0] CHAR_DOT   = 8'h2E;
  localparam logic [7:0] CHAR_SLASH = 8'h2F;
  localparam logic [7:0] CHAR_NL    = 8'h0A;

  localparam logic [63:0] RST_ALLOWED_METHOD = 64'd7628135;
  localparam logic        RST_METHOD_ENABLE  = 1'b1;
  localparam logic [63:0] RST_EXT [4] = '{
    64'd465692813358, 64'd1954051118, 64'd1936941870, 64'd7563822
  };
  localparam logic [2:0]  RST_EXT_COUNT    = 3'd4;
  localparam logic [7:0]  RST_HEADER_LIMIT = 8'd50;

  // suspicious words, last character in the low byte
  localparam int unsigned BAD_WORDS = 10;
  localparam logic [47:0] BAD_PAT [BAD_WORDS] = '{
    48'h0000_6578_6563, // exec
    48'h0000_6576_616c, // eval
    48'h7379_7374_656d, // system
    48'h0000_0063_6d64, // cmd
    48'h7363_7269_7074, // script
    48'h7061_7373_7764, // passwd
    48'h7368_6164_6f77, // shadow
    48'h636f_6e66_6967, // config
    48'h0000_0070_6870, // php
    48'h0000_0061_7370  // asp
  };
  localparam logic [47:0] BAD_MASK [BAD_WORDS] = '{
    48'h0000_ffff_ffff, 48'h0000_ffff_ffff, 48'hffff_ffff_ffff,
    48'h0000_00ff_ffff, 48'hffff_ffff_ffff, 48'hffff_ffff_ffff,
    48'hffff_ffff_ffff, 48'hffff_ffff_ffff, 48'h0000_00ff_ffff,
    48'h0000_00ff_ffff
  };

  typedef enum logic [1:0] {
    PART_METHOD = 2'd0,
    PART_PATH   = 2'd1,
    PART_HEADER = 2'd2,
    PART_NONE   = 2'd3
  } part_e;

  typedef enum logic [1:0] {
    VERDICT_OK         = 2'd0,
    VERDICT_BAD_METHOD = 2'd1,
    VERDICT_BAD_PATH   = 2'd2,
    VERDICT_HEADERS    = 2'd3
  } verdict_e;

  typedef enum logic [2:0] {
    REG_ALLOWED_METHOD = 3'd0,
    REG_METHOD_ENABLE  = 3'd1,
    REG_EXT_0          = 3'd2,
    REG_EXT_1          = 3'd3,
    REG_EXT_2          = 3'd4,
    REG_EXT_3          = 3'd5,
    REG_EXT_COUNT      = 3'd6,
    REG_HEADER_LIMIT   = 3'd7
  } reg_idx_e;

  typedef struct packed {
    part_e      part;
    logic [7:0] ch;
    logic       last;
    logic       is_dot;
    logic       is_slash;
    logic       is_nl;
  } ent_t;

  typedef struct packed {
    logic [63:0] allowed_method;
    logic        method_enable;
    logic [2:0]  ext_count;
    logic [7:0]  header_limit;
  } cfg_t;

  function automatic logic [7:0] fold_byte(logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5A) r = c + 8'h20;
    return r;
  endfunction

  function automatic logic bad_word_hit(logic [47:0] w);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < BAD_WORDS; i++) begin
      if ((w & BAD_MASK[i]) == BAD_PAT[i]) hit = 1'b1;
    end
    return hit;
  endfunction

endpackage

// ===== rtl/core/hrv_intf.sv =====
// hrv_intf: valid/ready channels for request bytes and verdicts
// depends on nothing
interface hrv_byte_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] char_byte;
  logic       end_of_request;

  modport source (output valid, req_type, char_byte, end_of_request, input ready);
  modport sink   (input valid, req_type, char_byte, end_of_request, output ready);
endinterface

interface hrv_verdict_if;
  logic       valid;
  logic       ready;
  logic [1:0] verdict;

  modport source (output valid, verdict, input ready);
  modport sink   (input valid, verdict, output ready);
endinterface

// ===== rtl/core/http_request_validator.sv =====
// http_request_validator: top level; front end, byte queue, back end, register file
// depends on hrv_pkg, hrv_intf, hrv_cfg_regs, hrv_front, hrv_fifo, hrv_back
//
//   channel   dir  payload                                handshake
//   req_i     in   req_type, char_byte, end_of_request    valid / ready
//   rsp_o     out  verdict                                valid / ready
//   apb       in   paddr, pwdata -> prdata                psel, penable, pready
//
// one byte per cycle sustained while the byte queue is not full; a verdict is registered
// in the back end after its last byte has passed through the byte queue
// the four-entry byte queue decouples intake from the back end, so req_i only
// stalls when the queue fills behind a verdict that rsp_o has not taken
// a byte at the head of the queue waits on rsp_o only when it is final; reset clears
// all request state and restores the register defaults
module http_request_validator #(
  parameter int unsigned PATH_MAX_LEN    = 255,
  parameter int unsigned EXTENSION_SLOTS = 4
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  hrv_byte_if.sink                        req_i,
  hrv_verdict_if.source                   rsp_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [hrv_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [hrv_pkg::APB_DATA_W-1:0] pwdata,
  output logic [hrv_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready
);

  localparam int unsigned LEN_W = $clog2(PATH_MAX_LEN + 2);

  hrv_pkg::cfg_t cfg;
  logic [63:0]   ext_slot [EXTENSION_SLOTS];
  hrv_pkg::ent_t push_ent, pop_ent;
  logic          push, pop, full, avail;

  hrv_cfg_regs #(
    .EXTENSION_SLOTS(EXTENSION_SLOTS)
  ) u_cfg (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cfg_o(cfg), .ext_slot_o(ext_slot)
  );

  hrv_front u_front (
    .req(req_i), .full_i(full), .push_o(push), .ent_o(push_ent)
  );

  hrv_fifo u_fifo (
    .clk_i, .rst_ni, .push_i(push), .wdata_i(push_ent), .full_o(full),
    .pop_i(pop), .valid_o(avail), .rdata_o(pop_ent)
  );

  hrv_back #(
    .PATH_MAX_LEN(PATH_MAX_LEN), .EXTENSION_SLOTS(EXTENSION_SLOTS), .LEN_W(LEN_W)
  ) u_back (
    .clk_i, .rst_ni, .ent_valid_i(avail), .ent_i(pop_ent), .ent_pop_o(pop),
    .cfg_i(cfg), .ext_slot_i(ext_slot), .rsp(rsp_o)
  );

endmodule

// ===== rtl/core/hrv_cfg_regs.sv =====
// hrv_cfg_regs: apb register file for the method word, extension slots and limits
// depends on hrv_pkg
module hrv_cfg_regs #(
  parameter int unsigned EXTENSION_SLOTS = 4
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [hrv_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [hrv_pkg::APB_DATA_W-1:0] pwdata,
  output logic [hrv_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready,
  output hrv_pkg::cfg_t                   cfg_o,
  output logic [63:0]                     ext_slot_o [EXTENSION_SLOTS]
);

  hrv_pkg::reg_idx_e idx;
  logic              wr_en;
  logic [63:0]       ext_q [EXTENSION_SLOTS];
  logic [63:0]       method_q;
  logic              enable_q;
  logic [2:0]        count_q;
  logic [7:0]        limit_q;

  assign pready = 1'b1;
  assign idx    = hrv_pkg::reg_idx_e'(paddr[hrv_pkg::APB_ADDR_W-1:3]);
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      method_q <= hrv_pkg::RST_ALLOWED_METHOD;
      enable_q <= hrv_pkg::RST_METHOD_ENABLE;
      count_q  <= hrv_pkg::RST_EXT_COUNT;
      limit_q  <= hrv_pkg::RST_HEADER_LIMIT;
      for (int k = 0; k < EXTENSION_SLOTS; k++) ext_q[k] <= hrv_pkg::RST_EXT[k];
    end else if (wr_en) begin
      if (idx == hrv_pkg::REG_ALLOWED_METHOD) method_q <= pwdata;
      if (idx == hrv_pkg::REG_METHOD_ENABLE)  enable_q <= pwdata[0];
      if (idx == hrv_pkg::REG_EXT_COUNT)      count_q  <= pwdata[2:0];
      if (idx == hrv_pkg::REG_HEADER_LIMIT)   limit_q  <= pwdata[7:0];
      for (int k = 0; k < EXTENSION_SLOTS; k++) begin
        if (idx == hrv_pkg::reg_idx_e'(3'(hrv_pkg::REG_EXT_0) + 3'(k))) ext_q[k] <= pwdata;
      end
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      hrv_pkg::REG_ALLOWED_METHOD: prdata = method_q;
      hrv_pkg::REG_METHOD_ENABLE:  prdata = {63'd0, enable_q};
      hrv_pkg::REG_EXT_0, hrv_pkg::REG_EXT_1, hrv_pkg::REG_EXT_2, hrv_pkg::REG_EXT_3: begin
        for (int k = 0; k < EXTENSION_SLOTS; k++) begin
          if (idx == hrv_pkg::reg_idx_e'(3'(hrv_pkg::REG_EXT_0) + 3'(k))) prdata = ext_q[k];
        end
      end
      hrv_pkg::REG_EXT_COUNT:      prdata = {61'd0, count_q};
      hrv_pkg::REG_HEADER_LIMIT:   prdata = {56'd0, limit_q};
    endcase
  end

  assign cfg_o.allowed_method = method_q;
  assign cfg_o.method_enable  = enable_q;
  assign cfg_o.ext_count      = count_q;
  assign cfg_o.header_limit   = limit_q;
  assign ext_slot_o           = ext_q;

endmodule

// ===== rtl/core/hrv_front.sv =====
// hrv_front: takes request bytes, folds case and tags the characters the back end tests
// depends on hrv_pkg, hrv_intf
module hrv_front (
  hrv_byte_if.sink      req,
  input  logic          full_i,
  output logic          push_o,
  output hrv_pkg::ent_t ent_o
);

  logic [7:0] folded;

  assign folded    = hrv_pkg::fold_byte(req.char_byte);
  assign req.ready = !full_i;
  assign push_o    = req.valid && !full_i;

  always_comb begin
    ent_o.part     = hrv_pkg::part_e'(req.req_type);
    ent_o.ch       = folded;
    ent_o.last     = req.end_of_request;
    ent_o.is_dot   = (folded == hrv_pkg::CHAR_DOT);
    ent_o.is_slash = (folded == hrv_pkg::CHAR_SLASH);
    ent_o.is_nl    = (req.char_byte == hrv_pkg::CHAR_NL);
  end

endmodule

// ===== rtl/core/hrv_fifo.sv =====
// hrv_fifo: short queue of classified bytes between front and back end
// depends on hrv_pkg
module hrv_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  hrv_pkg::ent_t wdata_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output hrv_pkg::ent_t rdata_o
);

  localparam int unsigned PW = hrv_pkg::FIFO_PTR_W;

  hrv_pkg::ent_t mem_q [hrv_pkg::FIFO_DEPTH];
  logic [PW:0]   wr_q, wr_d;
  logic [PW:0]   rd_q, rd_d;

  assign full_o  = (wr_q[PW] != rd_q[PW]) && (wr_q[PW-1:0] == rd_q[PW-1:0]);
  assign valid_o = (wr_q != rd_q);
  assign rdata_o = mem_q[rd_q[PW-1:0]];
  assign wr_d    = wr_q + (PW+1)'(push_i);
  assign rd_d    = rd_q + (PW+1)'(pop_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
    end else begin
      wr_q <= wr_d;
      rd_q <= rd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q[PW-1:0]] <= wdata_i;
  end

endmodule

// ===== rtl/core/hrv_back.sv =====
// hrv_back: per-request state, path pattern checks and the verdict register
// depends on hrv_pkg, hrv_intf
module hrv_back #(
  parameter int unsigned PATH_MAX_LEN    = 255,
  parameter int unsigned EXTENSION_SLOTS = 4,
  parameter int unsigned LEN_W           = 9
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          ent_valid_i,
  input  hrv_pkg::ent_t ent_i,
  output logic          ent_pop_o,
  input  hrv_pkg::cfg_t cfg_i,
  input  logic [63:0]   ext_slot_i [EXTENSION_SLOTS],
  hrv_verdict_if.source rsp
);

  localparam int unsigned SW = hrv_pkg::STR_LEN_W;

  logic [63:0]     mword_q, mword_n, mword_d;
  logic [SW-1:0]   mlen_q, mlen_n, mlen_d;
  logic [LEN_W-1:0] plen_q, plen_n, plen_d;
  logic [39:0]     recent_q, recent_n, recent_d;
  logic            rej_q, rej_n, rej_d;
  logic            dot_q, dot_n, dot_d;
  logic [63:0]     eword_q, eword_n, eword_d;
  logic [SW-1:0]   elen_q, elen_n, elen_d;
  logic [hrv_pkg::NL_W-1:0] nl_q, nl_n, nl_d;

  logic              out_valid_q, out_valid_d;
  hrv_pkg::verdict_e verdict_q, verdict_d, judged;
  logic [47:0]       window;
  logic              ext_ok, method_ok, path_bad, take_last;

  assign ent_pop_o   = ent_valid_i && (!ent_i.last || !out_valid_q || rsp.ready);
  assign take_last   = ent_pop_o && ent_i.last;
  assign window      = {recent_q, ent_i.ch};
  assign rsp.valid   = out_valid_q;
  assign rsp.verdict = verdict_q;

  // state after this byte
  always_comb begin
    mword_n  = mword_q;
    mlen_n   = mlen_q;
    plen_n   = plen_q;
    recent_n = recent_q;
    rej_n    = rej_q;
    dot_n    = dot_q;
    eword_n  = eword_q;
    elen_n   = elen_q;
    nl_n     = nl_q;
    case (ent_i.part)
      hrv_pkg::PART_METHOD: begin
        if (mlen_q < hrv_pkg::STR_MAX) begin
          for (int i = 0; i < 8; i++) begin
            if (mlen_q == SW'(i)) mword_n[8*i +: 8] = ent_i.ch;
          end
          mlen_n = mlen_q + SW'(1);
        end else begin
          mlen_n = hrv_pkg::STR_OVER;
        end
      end
      hrv_pkg::PART_PATH: begin
        if (plen_q == '0 && ent_i.is_dot) rej_n = 1'b1;
        if (plen_q != '0 && recent_q[7:0] == ent_i.ch && (ent_i.is_dot || ent_i.is_slash))
          rej_n = 1'b1;
        if (hrv_pkg::bad_word_hit(window)) rej_n = 1'b1;
        recent_n = window[39:0];
        if (plen_q < LEN_W'(PATH_MAX_LEN + 1)) plen_n = plen_q + LEN_W'(1);
        if (ent_i.is_dot) begin
          dot_n   = 1'b1;
          eword_n = {56'd0, hrv_pkg::CHAR_DOT};
          elen_n  = SW'(1);
        end else if (dot_q) begin
          if (elen_q < hrv_pkg::STR_MAX) begin
            for (int i = 0; i < 8; i++) begin
              if (elen_q == SW'(i)) eword_n[8*i +: 8] = ent_i.ch;
            end
            elen_n = elen_q + SW'(1);
          end else begin
            elen_n = hrv_pkg::STR_OVER;
          end
        end
      end
      hrv_pkg::PART_HEADER: begin
        if (ent_i.is_nl && !nl_q[hrv_pkg::NL_W-1]) nl_n = nl_q + hrv_pkg::NL_W'(1);
      end
      default: ;
    endcase
  end

  // verdict on the state after the last byte; checks in priority order
  always_comb begin
    ext_ok = 1'b0;
    if (dot_n && elen_n <= hrv_pkg::STR_MAX) begin
      for (int i = 0; i < EXTENSION_SLOTS; i++) begin
        if (3'(i) < cfg_i.ext_count && ext_slot_i[i] == eword_n) ext_ok = 1'b1;
      end
    end
    method_ok = cfg_i.method_enable && mlen_n <= hrv_pkg::STR_MAX &&
                mword_n == cfg_i.allowed_method;
    path_bad  = plen_n == '0 || plen_n > LEN_W'(PATH_MAX_LEN) || rej_n || !ext_ok;
    if (!method_ok)                              judged = hrv_pkg::VERDICT_BAD_METHOD;
    else if (path_bad)                           judged = hrv_pkg::VERDICT_BAD_PATH;
    else if (nl_n > {1'b0, cfg_i.header_limit}) judged = hrv_pkg::VERDICT_HEADERS;
    else                                         judged = hrv_pkg::VERDICT_OK;
  end

  always_comb begin
    mword_d  = take_last ? '0 : mword_n;
    mlen_d   = take_last ? '0 : mlen_n;
    plen_d   = take_last ? '0 : plen_n;
    recent_d = take_last ? '0 : recent_n;
    rej_d    = take_last ? 1'b0 : rej_n;
    dot_d    = take_last ? 1'b0 : dot_n;
    eword_d  = take_last ? '0 : eword_n;
    elen_d   = take_last ? '0 : elen_n;
    nl_d     = take_last ? '0 : nl_n;
    out_valid_d = out_valid_q;
    verdict_d   = verdict_q;
    if (take_last) begin
      out_valid_d = 1'b1;
      verdict_d   = judged;
    end else if (rsp.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mword_q     <= '0;
      mlen_q      <= '0;
      plen_q      <= '0;
      recent_q    <= '0;
      rej_q       <= 1'b0;
      dot_q       <= 1'b0;
      eword_q     <= '0;
      elen_q      <= '0;
      nl_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (ent_pop_o) begin
        mword_q  <= mword_d;
        mlen_q   <= mlen_d;
        plen_q   <= plen_d;
        recent_q <= recent_d;
        rej_q    <= rej_d;
        dot_q    <= dot_d;
        eword_q  <= eword_d;
        elen_q   <= elen_d;
        nl_q     <= nl_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    verdict_q <= verdict_d;
  end

endmodule

// ===== rtl/core/hrv_checker.sv =====
// hrv_checker: port-level checks on the validator, bound to the top level
// depends on hrv_pkg, http_request_validator
module hrv_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            in_last,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [1:0]                      out_verdict,
  input logic                            psel,
  input logic                            penable,
  input logic                            pwrite,
  input logic [hrv_pkg::APB_ADDR_W-1:0] paddr,
  input logic [hrv_pkg::APB_DATA_W-1:0] pwdata,
  input logic [hrv_pkg::APB_DATA_W-1:0] prdata,
  input logic                            pready
);

  logic [3:0] pend_q;
  logic       req_done, rsp_done, limit_wr;

  assign req_done = in_valid && in_ready && in_last;
  assign rsp_done = out_valid && out_ready;
  assign limit_wr = psel && penable && pwrite &&
                    paddr[hrv_pkg::APB_ADDR_W-1:3] == hrv_pkg::REG_HEADER_LIMIT;

  // requests whose verdict has not been taken yet
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) pend_q <= '0;
    else         pend_q <= pend_q + 4'(req_done) - 4'(rsp_done);
  end

  a_no_spurious_verdict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> pend_q != '0)
    else $error("verdict without a finished request");

  a_verdict_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_verdict))
    else $error("stalled verdict changed");

  a_pready_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready)
    else $error("pready dropped");

  a_limit_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    limit_wr |=> (paddr[hrv_pkg::APB_ADDR_W-1:3] != hrv_pkg::REG_HEADER_LIMIT ||
                  prdata[7:0] == $past(pwdata[7:0])))
    else $error("header limit readback mismatch");

endmodule

bind http_request_validator hrv_checker u_hrv_checker (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .in_valid(req_i.valid), .in_ready(req_i.ready), .in_last(req_i.end_of_request),
  .out_valid(rsp_o.valid), .out_ready(rsp_o.ready), .out_verdict(rsp_o.verdict),
  .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
  .pwdata(pwdata), .prdata(prdata), .pready(pready)
);
